// File: rtl/chkg_pkg.sv
// ----------------------------------------------------------------------------
// chkg_pkg
// Constants and hash round helpers for the counter hash key generator.
// ----------------------------------------------------------------------------
package chkg_pkg;

   localparam int unsigned WordWidth    = 32;
   localparam int unsigned IndexWidth   = 64;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned NumMix       = 5;
   localparam int unsigned NumStages    = 2 * NumMix;

   localparam logic [WordWidth-1:0] MulA   = 32'd747796405;
   localparam logic [WordWidth-1:0] AddA   = 32'd2891336453;
   localparam logic [WordWidth-1:0] MulB   = 32'd277803737;
   localparam logic [WordWidth-1:0] Golden = 32'h9e3779b9;
   localparam logic [WordWidth-1:0] SubMul = 32'h85ebca6b;
   // (v + Golden) * MulA + AddA folded into one constant offset
   localparam logic [WordWidth-1:0] StreamAdd = 32'(Golden * MulA + AddA);

   localparam logic [3:0] ShiftBase = 4'd4;
   localparam int unsigned FinShift = 22;

   // register index, taken from paddr[2]
   localparam logic RegSeed = 1'b0;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type lo;
      word_type hi;
      word_type sub;
   } operand_type;

   function automatic word_type mix_s(input word_type v);
      mix_s = v * MulA + AddA;
   endfunction

   function automatic word_type mix_w(input word_type s);
      logic [4:0] sh;
      sh    = {1'b0, s[31:28]} + {1'b0, ShiftBase};
      mix_w = ((s >> sh) ^ s) * MulB;
   endfunction

   function automatic word_type mix_fin(input word_type w);
      mix_fin = (w >> FinShift) ^ w;
   endfunction

endpackage

// File: rtl/counter_hash_key_generator_unit.sv
// ----------------------------------------------------------------------------
// counter_hash_key_generator_unit
// Counter based key generator: five chained PCG style hash rounds over
// stream, seed, draw index words and scaled sub draw, one key per word.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  input     req_stream_id, req_draw_index,         start & !busy
//            req_sub_draw
//  result    rsp_key                                rsp_valid, one cycle strobe
//  csr       csr_p*                                 APB, seed at byte 0
//
//  One word is accepted per cycle.
//  Each hash round uses two registered multiplier stages (ten in all),
//  plus the output register.
//  busy stays low: the receiver cannot stall, so nothing backs up.
//  Synchronous reset clears valid bits and seed (seed resets to 0).
// ----------------------------------------------------------------------------
module counter_hash_key_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [chkg_pkg::WordWidth-1:0]      req_stream_id,
   input  logic signed [chkg_pkg::IndexWidth-1:0] req_draw_index,
   input  logic [chkg_pkg::WordWidth-1:0]      req_sub_draw,
   output logic                                rsp_valid,
   output logic [chkg_pkg::WordWidth-1:0]      rsp_key,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [chkg_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [chkg_pkg::WordWidth-1:0]      csr_pwdata,
   output logic [chkg_pkg::WordWidth-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned Last = chkg_pkg::NumStages - 1;

   chkg_pkg::word_type    seed_ff;
   chkg_pkg::word_type    seed_in;
   logic                  seed_wr;

   logic                  valid_ff [chkg_pkg::NumStages];
   logic                  valid_in [chkg_pkg::NumStages];
   chkg_pkg::word_type    data_ff  [chkg_pkg::NumStages];
   chkg_pkg::word_type    data_in  [chkg_pkg::NumStages];
   chkg_pkg::operand_type op_ff    [Last];
   chkg_pkg::operand_type op_in    [Last];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   chkg_pkg::word_type    rsp_key_ff;
   chkg_pkg::word_type    rsp_key_in;

   // csr
   assign csr_pready = 1'b1;
   assign seed_wr    = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == chkg_pkg::RegSeed);
   assign seed_in    = seed_wr ? csr_pwdata : seed_ff;
   assign csr_prdata = (csr_paddr[2] == chkg_pkg::RegSeed) ? seed_ff : '0;

   assign busy = 1'b0;

   function automatic chkg_pkg::word_type round_op(input int unsigned j,
                                                   input chkg_pkg::operand_type op,
                                                   input chkg_pkg::word_type seed);
      chkg_pkg::word_type r;
      unique case (j)
         1:       r = seed;
         2:       r = op.lo;
         3:       r = op.hi;
         default: r = op.sub;
      endcase
      return r;
   endfunction

   always_comb begin
      valid_in[0] = start & ~busy;
      data_in[0]  = req_stream_id * chkg_pkg::MulA + chkg_pkg::StreamAdd;
      op_in[0].lo  = req_draw_index[chkg_pkg::WordWidth-1:0];
      op_in[0].hi  = req_draw_index[chkg_pkg::IndexWidth-1:chkg_pkg::WordWidth];
      op_in[0].sub = req_sub_draw * chkg_pkg::SubMul;
      for (int unsigned p = 1; p < chkg_pkg::NumStages; p++) begin
         valid_in[p] = valid_ff[p-1];
         if (p % 2 == 1) begin
            data_in[p] = chkg_pkg::mix_w(data_ff[p-1]);
         end else begin
            data_in[p] = chkg_pkg::mix_s(chkg_pkg::mix_fin(data_ff[p-1])
                                         ^ round_op(p / 2, op_ff[p-1], seed_ff));
         end
      end
      for (int unsigned p = 1; p < Last; p++) begin
         op_in[p] = op_ff[p-1];
      end
      rsp_valid_in = valid_ff[Last];
      rsp_key_in   = chkg_pkg::mix_fin(data_ff[Last]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int unsigned p = 0; p < chkg_pkg::NumStages; p++) begin
            valid_ff[p] <= 1'b0;
         end
      end else begin
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int unsigned p = 0; p < chkg_pkg::NumStages; p++) begin
            valid_ff[p] <= valid_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int unsigned p = 0; p < chkg_pkg::NumStages; p++) begin
         data_ff[p] <= data_in[p];
      end
      for (int unsigned p = 0; p < Last; p++) begin
         op_ff[p] <= op_in[p];
      end
      rsp_key_ff <= rsp_key_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_key   = rsp_key_ff;

`ifndef SYNTH
   a_start_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start |-> ##11 rsp_valid)
      else $error("accepted word did not produce a key after 11 cycles");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 11))
      else $error("key strobe without an accepted word");

   a_seed_write: assert property (@(posedge clock) disable iff (reset)
      seed_wr |=> seed_ff == $past(csr_pwdata))
      else $error("seed register not updated by write");
`endif

endmodule
